// ----- src/bdt_pkg.sv -----
// ----------------------------------------------------------------------------
// bdt_pkg
// Shared types and constants for the barrier dirty tracker.
// ----------------------------------------------------------------------------
package bdt_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned MASK_W  = 32;
  // texture-update barrier bit, cleared in every entry by a query that holds it and hits
  localparam int unsigned TEX_BIT = 8;

  localparam logic [MASK_W-1:0] MASK_ALL_ONES = '1;

  // operation codes carried in the kind field
  typedef enum logic [1:0] {
    KIND_MARK  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RESP
  } state_t;

  // write request toward the key and mask memories
  typedef struct packed {
    logic              key_we;
    logic              mask_we;
    logic [KEY_W-1:0]  key;
    logic [MASK_W-1:0] mask;
  } store_wr_t;

  // one result item
  typedef struct packed {
    logic needs_barrier;
    logic table_full;
  } result_t;

endpackage

// ----- src/bdt_store.sv -----
// ----------------------------------------------------------------------------
// bdt_store
// Key and needed-mask memories: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bdt_store #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(ENTRIES)-1:0]    rd_addr,
  input  bdt_pkg::store_wr_t            wr,
  input  logic [$clog2(ENTRIES)-1:0]    wr_addr,
  output logic [bdt_pkg::KEY_W-1:0]     key_q,
  output logic [bdt_pkg::MASK_W-1:0]    mask_q
);

  logic [bdt_pkg::KEY_W-1:0]  key_mem  [ENTRIES];
  logic [bdt_pkg::MASK_W-1:0] mask_mem [ENTRIES];

  // key memory
  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[wr_addr] <= wr.key;
    end
    if (rd_en) begin
      key_q <= key_mem[rd_addr];
    end
  end

  // needed-mask memory
  always_ff @(posedge clk) begin
    if (wr.mask_we) begin
      mask_mem[wr_addr] <= wr.mask;
    end
    if (rd_en) begin
      mask_q <= mask_mem[rd_addr];
    end
  end

endmodule

// ----- src/bdt_seq.sv -----
// ----------------------------------------------------------------------------
// bdt_seq
// Sequencer: for a mark or a query, scans the table one entry a cycle through a single key
// comparator, then applies the update in the write state; a clear skips both.
// ----------------------------------------------------------------------------
module bdt_seq #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    kind,
  input  logic [bdt_pkg::KEY_W-1:0]     object_key,
  input  logic [bdt_pkg::MASK_W-1:0]    barrier_mask,
  // memory side
  output logic                          rd_en,
  output logic [$clog2(ENTRIES)-1:0]    rd_addr,
  output bdt_pkg::store_wr_t            wr,
  output logic [$clog2(ENTRIES)-1:0]    wr_addr,
  input  logic [bdt_pkg::KEY_W-1:0]     key_q,
  input  logic [bdt_pkg::MASK_W-1:0]    mask_q,
  // result side
  output logic                          res_valid,
  input  logic                          res_take,
  output bdt_pkg::result_t              res
);

  localparam int unsigned  IDXW     = $clog2(ENTRIES);
  localparam logic [IDXW:0] ENT_CNT = (IDXW+1)'(ENTRIES);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);

  bdt_pkg::state_t state, state_next;
  bdt_pkg::kind_t  kind_in;
  bdt_pkg::kind_t  kind_reg;

  logic [bdt_pkg::KEY_W-1:0]  key_reg;
  logic [bdt_pkg::MASK_W-1:0] mask_reg;
  logic [IDXW:0]              rd_idx;
  logic                       pend;
  logic [IDXW-1:0]            pend_idx;
  logic                       free_found;
  logic [IDXW-1:0]            free_idx;
  logic                       found;
  logic [IDXW-1:0]            slot;
  logic [bdt_pkg::MASK_W-1:0] ent_mask;
  logic [ENTRIES-1:0]         valid_bits;
  logic [ENTRIES-1:0]         tex_bits;
  bdt_pkg::result_t           res_reg;

  logic match;
  logic last_cmp;
  logic accept;
  logic query_hit;
  logic mark_ok;

  assign kind_in = bdt_pkg::kind_t'(kind);
  assign accept  = in_valid && in_ready;

  // shared comparator on the entry read last cycle
  assign match    = pend && valid_bits[pend_idx] && (key_q == key_reg);
  assign last_cmp = pend && (pend_idx == LAST_IDX);

  assign query_hit = found && (|(ent_mask & mask_reg));
  assign mark_ok   = found || free_found;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bdt_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (kind_in)
            bdt_pkg::KIND_MARK, bdt_pkg::KIND_QUERY: state_next = bdt_pkg::ST_SCAN;
            default:                                 state_next = bdt_pkg::ST_RESP;
          endcase
        end
      end
      bdt_pkg::ST_SCAN: begin
        if (match || last_cmp) begin
          state_next = bdt_pkg::ST_WRITE;
        end
      end
      bdt_pkg::ST_WRITE: state_next = bdt_pkg::ST_RESP;
      bdt_pkg::ST_RESP: begin
        if (res_take) begin
          state_next = bdt_pkg::ST_IDLE;
        end
      end
      default: state_next = bdt_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = (state == bdt_pkg::ST_IDLE);
    res_valid  = (state == bdt_pkg::ST_RESP);
    res        = res_reg;
    rd_en      = (state == bdt_pkg::ST_SCAN) && (rd_idx < ENT_CNT);
    rd_addr    = rd_idx[IDXW-1:0];
    wr.key     = key_reg;
    wr.key_we  = 1'b0;
    wr.mask_we = 1'b0;
    wr.mask    = ent_mask & ~mask_reg;
    wr_addr    = slot;
    if (state == bdt_pkg::ST_WRITE) begin
      if (kind_reg == bdt_pkg::KIND_MARK) begin
        wr.mask    = bdt_pkg::MASK_ALL_ONES;
        wr.mask_we = mark_ok;
        wr.key_we  = !found && free_found;
        wr_addr    = found ? slot : free_idx;
      end else begin
        wr.mask_we = query_hit;
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (accept && kind_in == bdt_pkg::KIND_CLEAR) begin
      valid_bits <= '0;
    end else if (wr.key_we) begin
      valid_bits[wr_addr] <= 1'b1;
    end
  end

  // texture-update bit of each entry, kept apart for the broadcast clear
  always_ff @(posedge clk) begin
    if (state == bdt_pkg::ST_WRITE) begin
      if (kind_reg == bdt_pkg::KIND_MARK) begin
        if (mark_ok) begin
          tex_bits[wr_addr] <= 1'b1;
        end
      end else if (query_hit && mask_reg[bdt_pkg::TEX_BIT]) begin
        tex_bits <= '0;
      end
    end
  end

  // scan pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (accept) begin
      pend <= 1'b0;
    end else begin
      pend <= rd_en;
    end
  end

  // operand capture, scan progress and result
  always_ff @(posedge clk) begin
    if (accept) begin
      key_reg    <= object_key;
      mask_reg   <= barrier_mask;
      kind_reg   <= kind_in;
      rd_idx     <= '0;
      free_found <= 1'b0;
      found      <= 1'b0;
      res_reg    <= '0;
    end else begin
      if (rd_en) begin
        rd_idx <= rd_idx + 1'b1;
      end
      pend_idx <= rd_idx[IDXW-1:0];
      if (state == bdt_pkg::ST_SCAN && pend) begin
        if (match) begin
          found    <= 1'b1;
          slot     <= pend_idx;
          ent_mask <= {mask_q[bdt_pkg::MASK_W-1:bdt_pkg::TEX_BIT+1],
                       tex_bits[pend_idx],
                       mask_q[bdt_pkg::TEX_BIT-1:0]};
        end else if (!valid_bits[pend_idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= pend_idx;
        end
      end
      if (state == bdt_pkg::ST_WRITE) begin
        res_reg.needs_barrier <= (kind_reg == bdt_pkg::KIND_QUERY) && query_hit;
        res_reg.table_full    <= (kind_reg == bdt_pkg::KIND_MARK) && !mark_ok;
      end
    end
  end

endmodule

// ----- src/barrier_dirty_tracker.sv -----
// ----------------------------------------------------------------------------
// barrier_dirty_tracker
// Keyed table of objects and the memory barriers each one still needs.
// ----------------------------------------------------------------------------
// One item is handled at a time. A mark or a query walks the table one entry
// per cycle through a single 64-bit key comparator fed by the key memory's one
// read port, stopping at the first matching key, then passes through a write
// state for the table update and a response state that holds the result until
// the output register takes it. A clear or an unused kind goes straight to the
// response state. The result sits in an output register, so the next item can
// be taken while it waits. There is no clearing pass after reset.
module barrier_dirty_tracker #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    kind,
  input  logic [bdt_pkg::KEY_W-1:0]     object_key,
  input  logic [bdt_pkg::MASK_W-1:0]    barrier_mask,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          needs_barrier,
  output logic                          table_full
);

  localparam int unsigned IDXW = $clog2(ENTRIES);

  logic                       rd_en;
  logic [IDXW-1:0]            rd_addr;
  bdt_pkg::store_wr_t         wr;
  logic [IDXW-1:0]            wr_addr;
  logic [bdt_pkg::KEY_W-1:0]  key_q;
  logic [bdt_pkg::MASK_W-1:0] mask_q;
  logic                       res_valid;
  logic                       res_take;
  bdt_pkg::result_t           res;

  bdt_seq #(.ENTRIES(ENTRIES)) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .object_key   (object_key),
    .barrier_mask (barrier_mask),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .wr           (wr),
    .wr_addr      (wr_addr),
    .key_q        (key_q),
    .mask_q       (mask_q),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res          (res)
  );

  bdt_store #(.ENTRIES(ENTRIES)) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr      (wr),
    .wr_addr (wr_addr),
    .key_q   (key_q),
    .mask_q  (mask_q)
  );

  // output register, loads when empty or being drained
  assign res_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      needs_barrier <= res.needs_barrier;
      table_full    <= res.table_full;
    end
  end

endmodule

// ----- src/bdt_checker.sv -----
// ----------------------------------------------------------------------------
// bdt_checker
// Port-level checks for the barrier dirty tracker, bound to the top level.
// ----------------------------------------------------------------------------
module bdt_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic needs_barrier,
  input logic table_full
);

  // nothing to show right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // each transfer in starts a multi-cycle operation
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on back-to-back cycles");

  // a mark cannot hit and a query cannot be full
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(needs_barrier && table_full))
    else $error("both result flags set");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(needs_barrier) && $stable(table_full))
    else $error("stalled result changed");

endmodule

bind barrier_dirty_tracker bdt_checker u_bdt_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .needs_barrier (needs_barrier),
  .table_full    (table_full)
);
